// ===== rtl/phe_pkg.sv =====
// ----------------------------------------------------------------------------
// phe_pkg
// Shared types, widths and codes for the position histogram with extrema.
// ----------------------------------------------------------------------------
package phe_pkg;

	// field widths
	localparam int POS_W     = 32;
	localparam int BW_W      = 31;
	localparam int BIU_W     = 7;
	localparam int BIN_W     = 6;
	localparam int AMT_W     = 32;
	localparam int OCNT_W    = 32;
	localparam int MODE_W    = 2;
	localparam int LIM_W     = BIN_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// quotient bits kept by the divider; the top bit flags q >= 2**(QUO_W-1)
	localparam int QUO_W = BIU_W + 1;
	localparam int DSR_W = BW_W + QUO_W - 1;

	// parameter defaults
	localparam int NUM_BINS_DEF    = 64;
	localparam int COUNT_WIDTH_DEF = 32;

	// register reset values
	localparam logic signed [POS_W-1:0] UPPER_EDGE_RST  = '0;
	localparam logic [BW_W-1:0]         BIN_WIDTH_RST   = BW_W'(1);
	localparam logic [BIU_W-1:0]        BINS_IN_USE_RST = BIU_W'(64);

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	// input tdata: position, bin_select, amount
	localparam int IN_POS_LO = 0;
	localparam int IN_SEL_LO = IN_POS_LO + POS_W;
	localparam int IN_AMT_LO = IN_SEL_LO + BIN_W;
	localparam int IN_RAW_W  = IN_AMT_LO + AMT_W;
	localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;

	// output tdata: bin_index, bin_count, bin_min, bin_max, bin_emitted
	localparam int OUT_IDX_LO  = 0;
	localparam int OUT_CNT_LO  = OUT_IDX_LO + BIN_W;
	localparam int OUT_MIN_LO  = OUT_CNT_LO + OCNT_W;
	localparam int OUT_MAX_LO  = OUT_MIN_LO + POS_W;
	localparam int OUT_EMIT_LO = OUT_MAX_LO + POS_W;
	localparam int OUT_RAW_W   = OUT_EMIT_LO + 1;
	localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_EDGE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = CFG_IDX_W'(2);

	typedef enum logic [MODE_W-1:0] {
		MODE_BIN  = 2'd0,
		MODE_LOST = 2'd1,
		MODE_SET  = 2'd2,
		MODE_READ = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_status_t;

endpackage

// ===== rtl/phe_divider.sv =====
// ----------------------------------------------------------------------------
// phe_divider
// Bin finder: |upper_edge - position| / bin_width, one quotient bit a cycle,
// restoring, keeping only the low quotient bits plus an overflow bit.
// ----------------------------------------------------------------------------
module phe_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [phe_pkg::POS_W-1:0]  upper_edge,
	input  logic signed [phe_pkg::POS_W-1:0]  position,
	input  logic [phe_pkg::BW_W-1:0]          bin_width,
	output phe_pkg::div_status_t              status
);
	import phe_pkg::*;

	localparam int STEP_W = $clog2(QUO_W);

	logic                 abs_q;
	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [POS_W:0]       diff_q;
	logic [POS_W-1:0]     rem_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [QUO_W-1:0]     quo_q;

	logic [POS_W:0]       neg;
	logic [POS_W-1:0]     mag;
	logic [DSR_W:0]       trial;
	logic                 fits;

	assign neg   = (POS_W+1)'(0) - diff_q;
	assign mag   = diff_q[POS_W] ? neg[POS_W-1:0] : diff_q[POS_W-1:0];
	assign trial = {{(DSR_W-POS_W+1){1'b0}}, rem_q} - {1'b0, dsr_q};
	assign fits  = !trial[DSR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_q  <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				abs_q  <= 1'b1;
				busy_q <= 1'b0;
			end else if (abs_q) begin
				abs_q  <= 1'b0;
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// zero bin width lets every trial pass, so the overflow bit comes out set
	always_ff @(posedge clk) begin
		if (start) begin
			diff_q <= {upper_edge[POS_W-1], upper_edge} - {position[POS_W-1], position};
		end else if (abs_q) begin
			rem_q <= mag;
			dsr_q <= {bin_width, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[QUO_W-2:0], fits};
			dsr_q <= dsr_q >> 1;
			if (fits) begin
				rem_q <= trial[POS_W-1:0];
			end
		end
	end

	assign status.done     = done_q;
	assign status.quotient = quo_q;

endmodule

// ===== rtl/position_histogram_with_extrema.sv =====
// ----------------------------------------------------------------------------
// position_histogram_with_extrema
// Bins positions by distance from an upper edge and keeps per-bin count,
// minimum, maximum and emitted flag in one synchronous memory.
//
//  channel   direction  handshake             content
//  s_axis    in         tvalid/tready         tuser mode, tdata command fields
//  m_axis    out        tvalid/tready         tuser out_of_range, tdata bin state
//  cfg       in         cfg_we                cfg_index selects register
//
//  bin position (mode 0): the bit-serial divider (difference, magnitude,
//  8 quotient bits), then one memory read/write pass
//  modes 1 to 3: memory read, then update and write back
//  after reset a clearing pass over all NUM_BINS bins runs before the first beat
//  a result waiting on m_axis does not block the next input beat; the update
//  stage holds until the output register is free
// ----------------------------------------------------------------------------
module position_histogram_with_extrema #(
	parameter int NUM_BINS    = phe_pkg::NUM_BINS_DEF,
	parameter int COUNT_WIDTH = phe_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// position, bin_select, amount, zero pad
	input  logic [phe_pkg::IN_DATA_W-1:0]         s_axis_tdata,
	// mode
	input  logic [phe_pkg::MODE_W-1:0]            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// bin_index, bin_count, bin_min, bin_max, bin_emitted, zero pad
	output logic [phe_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// out_of_range
	output logic                                  m_axis_tuser,
	input  logic                                  cfg_we,
	input  logic [phe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [phe_pkg::CFG_W-1:0]             cfg_wdata
);
	import phe_pkg::*;

	localparam int AW      = $clog2(NUM_BINS);
	localparam int CW_EXT  = COUNT_WIDTH > AMT_W ? COUNT_WIDTH : AMT_W;
	localparam int EMIT_B  = 0;
	localparam int MAX_LO  = 1;
	localparam int MIN_LO  = MAX_LO + POS_W;
	localparam int CNT_LO  = MIN_LO + POS_W;
	localparam int WORD_W  = CNT_LO + COUNT_WIDTH;

	// configuration
	logic signed [POS_W-1:0] upper_edge_q;
	logic [BW_W-1:0]         bin_width_q;
	logic [BIU_W-1:0]        bins_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_edge_q  <= UPPER_EDGE_RST;
			bin_width_q   <= BIN_WIDTH_RST;
			bins_in_use_q <= BINS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UPPER_EDGE:  upper_edge_q  <= cfg_wdata[POS_W-1:0];
				CFG_BIN_WIDTH:   bin_width_q   <= cfg_wdata[BW_W-1:0];
				CFG_BINS_IN_USE: bins_in_use_q <= cfg_wdata[BIU_W-1:0];
				default: ;
			endcase
		end
	end

	// control
	state_t      state_q, state_d;
	logic [AW-1:0] clr_addr_q;
	logic        div_start;
	div_status_t div_st;
	logic        rd_en;
	logic [AW-1:0] rd_addr;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic        commit;
	logic        in_accept;
	logic        sel_oor;
	logic        quo_oor;
	logic        out_valid_q;

	// command registers
	mode_t                   mode_q;
	logic signed [POS_W-1:0] pos_q;
	logic [BIN_W-1:0]        sel_q;
	logic [AMT_W-1:0]        amt_q;
	logic [BIN_W-1:0]        bidx_q;
	logic [AW-1:0]           addr_q;
	logic                    skip_q;
	logic [LIM_W-1:0]        emitted_limit_q;

	logic [WORD_W-1:0] mem [NUM_BINS];
	logic [WORD_W-1:0] rd_data_q;

	logic signed [POS_W-1:0] in_pos;
	logic [BIN_W-1:0]        in_sel;

	assign in_pos    = s_axis_tdata[IN_POS_LO +: POS_W];
	assign in_sel    = s_axis_tdata[IN_SEL_LO +: BIN_W];
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign sel_oor   = 32'(in_sel) >= NUM_BINS;
	// overflow bit of the quotient always lands above bins_in_use
	assign quo_oor   = (div_st.quotient >= {1'b0, bins_in_use_q})
	                || (32'(div_st.quotient) >= NUM_BINS);

	phe_divider u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.upper_edge (upper_edge_q),
		.position   (in_pos),
		.bin_width  (bin_width_q),
		.status     (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = AW'(32'(in_sel));
		commit        = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(NUM_BINS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (mode_t'(s_axis_tuser) == MODE_BIN) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						rd_en   = !sel_oor;
						state_d = ST_UPD;
					end
				end
			end
			ST_DIV: begin
				rd_addr = AW'(32'(div_st.quotient));
				if (div_st.done) begin
					rd_en   = !quo_oor;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (!out_valid_q || m_axis_tready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q <= mode_t'(s_axis_tuser);
			pos_q  <= in_pos;
			sel_q  <= in_sel;
			amt_q  <= s_axis_tdata[IN_AMT_LO +: AMT_W];
			bidx_q <= in_sel;
			addr_q <= rd_addr;
			skip_q <= sel_oor;
		end else if (state_q == ST_DIV && div_st.done) begin
			skip_q <= quo_oor;
			addr_q <= rd_addr;
			bidx_q <= quo_oor ? '0 : div_st.quotient[BIN_W-1:0];
		end
	end

	// bin store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// read-modify-write of the addressed bin
	logic [COUNT_WIDTH-1:0]  r_cnt, n_cnt;
	logic signed [POS_W-1:0] r_min, r_max, n_min, n_max;
	logic                    r_emit, n_emit;
	logic [CW_EXT-1:0]       cnt_ext, amt_ext;
	logic [LIM_W-1:0]        sel_next;
	logic [WORD_W-1:0]       clr_word;

	assign r_cnt    = rd_data_q[CNT_LO +: COUNT_WIDTH];
	assign r_min    = rd_data_q[MIN_LO +: POS_W];
	assign r_max    = rd_data_q[MAX_LO +: POS_W];
	assign r_emit   = rd_data_q[EMIT_B];
	assign cnt_ext  = CW_EXT'(r_cnt);
	assign amt_ext  = CW_EXT'(amt_q);
	assign sel_next = {1'b0, sel_q} + LIM_W'(1);
	assign clr_word = {{COUNT_WIDTH{1'b0}}, POS_MAX, POS_MIN, 1'b0};

	always_comb begin
		n_cnt  = r_cnt;
		n_min  = r_min;
		n_max  = r_max;
		n_emit = r_emit;
		case (mode_q)
			MODE_BIN: begin
				if (r_cnt != '1) begin
					n_cnt = r_cnt + COUNT_WIDTH'(1);
				end
				if (pos_q <= r_min) begin
					n_min = pos_q;
				end
				if (pos_q >= r_max) begin
					n_max = pos_q;
				end
			end
			MODE_LOST: begin
				// only bins below the emitted limit lose particles
				if ({1'b0, sel_q} < emitted_limit_q) begin
					n_cnt = (amt_ext >= cnt_ext) ? '0
					      : COUNT_WIDTH'(cnt_ext - amt_ext);
				end
			end
			MODE_SET: begin
				n_cnt  = COUNT_WIDTH'(amt_ext);
				n_emit = 1'b1;
			end
			MODE_READ: ;
			default: ;
		endcase
	end

	assign wr_en   = (state_q == ST_CLEAR) || (commit && !skip_q);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
	assign wr_data = (state_q == ST_CLEAR) ? clr_word : {n_cnt, n_min, n_max, n_emit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitted_limit_q <= '0;
		end else if (commit && !skip_q && mode_q == MODE_SET && sel_next > emitted_limit_q) begin
			emitted_limit_q <= sel_next;
		end
	end

	// output register
	logic [BIN_W-1:0]        o_idx_q;
	logic                    o_oor_q;
	logic [OCNT_W-1:0]       o_cnt_q;
	logic signed [POS_W-1:0] o_min_q;
	logic signed [POS_W-1:0] o_max_q;
	logic                    o_emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			o_idx_q  <= bidx_q;
			o_oor_q  <= skip_q;
			o_cnt_q  <= skip_q ? '0 : OCNT_W'(CW_EXT'(n_cnt));
			o_min_q  <= skip_q ? '0 : n_min;
			o_max_q  <= skip_q ? '0 : n_max;
			o_emit_q <= skip_q ? 1'b0 : n_emit;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = o_oor_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-OUT_RAW_W){1'b0}},
	                        o_emit_q, o_max_q, o_min_q, o_cnt_q, o_idx_q};

	// one command in flight: an accepted beat closes the input until the command commits
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_axis_tready)
		else $error("input accepted while a command is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (emitted_limit_q >= $past(emitted_limit_q))
		      && (emitted_limit_q <= LIM_W'(1 << BIN_W)))
		else $error("emitted limit fell or ran past the bin range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q && !commit)
		else $error("result produced during the clearing pass");

endmodule

// ===== test/position_histogram_with_extrema_tb.sv =====
// ----------------------------------------------------------------------------
// position_histogram_with_extrema_tb
// Self-checking bench for the position histogram. Commands go in on s_axis in
// bursts with random gaps, while results are taken from m_axis under a
// changing stall pattern. A behavioural copy of the bins predicts every
// result, and each result is compared field by field as it arrives. A short
// directed part covers the edge cases. Random phases under several register
// settings follow, with one long receiver hold-off to fill the block.
// ----------------------------------------------------------------------------
module position_histogram_with_extrema_tb;
	import phe_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BEATS = 145;

	typedef struct packed {
		logic [BIN_W-1:0]  idx;
		logic              oor;
		logic [OCNT_W-1:0] cnt;
		logic [POS_W-1:0]  lo;
		logic [POS_W-1:0]  hi;
		logic              emit;
	} bin_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [MODE_W-1:0]     s_axis_tuser = MODE_BIN;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_UPPER_EDGE;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	// predictor copy of registers and bin stores
	logic signed [POS_W-1:0] upper_pos;
	logic [BW_W-1:0]         width_cfg;
	logic [BIU_W-1:0]        bins_cfg;
	logic [OCNT_W-1:0]       hist_count [NUM_BINS_DEF];
	logic signed [POS_W-1:0] hist_lo [NUM_BINS_DEF];
	logic signed [POS_W-1:0] hist_hi [NUM_BINS_DEF];
	logic                    hist_emitted [NUM_BINS_DEF];
	int                      emit_limit;

	bin_report_t pending_reports [$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;
	int          pattern_left = 0;
	int          stall_style = 0;

	position_histogram_with_extrema dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("position_histogram_with_extrema regression: fail");
			$finish;
		end
	end

	// works out the result of one command and updates the bins
	function automatic bin_report_t bin_command(mode_t m, logic signed [POS_W-1:0] pos,
			logic [BIN_W-1:0] sel, logic [AMT_W-1:0] amt);
		bin_report_t r;
		longint      span;
		longint      q;
		int          limit;
		int          b;
		r = '0;
		if (m == MODE_BIN) begin
			span = longint'(upper_pos) - longint'(pos);
			if (span < 0)
				span = -span;
			limit = (bins_cfg < NUM_BINS_DEF) ? int'(bins_cfg) : NUM_BINS_DEF;
			if (width_cfg == '0) begin
				r.oor = 1'b1;
				return r;
			end
			q = span / longint'(width_cfg);
			if (q >= limit) begin
				r.oor = 1'b1;
				return r;
			end
			b = int'(q);
			if (hist_count[b] != '1)
				hist_count[b]++;
			if (pos <= hist_lo[b])
				hist_lo[b] = pos;
			if (pos >= hist_hi[b])
				hist_hi[b] = pos;
		end else begin
			b = int'(sel);
			if (m == MODE_LOST) begin
				if (b < emit_limit) begin
					if (amt >= hist_count[b])
						hist_count[b] = '0;
					else
						hist_count[b] -= amt;
				end
			end else if (m == MODE_SET) begin
				hist_count[b] = amt;
				hist_emitted[b] = 1'b1;
				if (b + 1 > emit_limit)
					emit_limit = b + 1;
			end
		end
		r.idx  = BIN_W'(b);
		r.cnt  = hist_count[b];
		r.lo   = hist_lo[b];
		r.hi   = hist_hi[b];
		r.emit = hist_emitted[b];
		return r;
	endfunction

	// a position that lands in a bin in use, now and then just past the last one
	function automatic logic [POS_W-1:0] pos_near_bin();
		longint limit;
		longint b;
		longint span;
		longint p;
		limit = (bins_cfg < NUM_BINS_DEF) ? longint'(bins_cfg) : NUM_BINS_DEF;
		if (limit == 0 || width_cfg == '0)
			return $urandom;
		b = ($urandom_range(7, 0) == 0) ? limit : longint'($urandom_range(limit - 1, 0));
		span = b * longint'(width_cfg);
		if (width_cfg > 1)
			span += longint'($urandom_range(width_cfg - 1, 0));
		if ($urandom_range(1, 0) == 1)
			span = -span;
		p = longint'(upper_pos) + span;
		if (p > longint'(POS_MAX) || p < longint'(POS_MIN))
			p = longint'(upper_pos) - span;
		if (p > longint'(POS_MAX) || p < longint'(POS_MIN))
			return $urandom;
		return p[POS_W-1:0];
	endfunction

	task automatic send_beat(mode_t m, logic [POS_W-1:0] pos, logic [BIN_W-1:0] sel,
			logic [AMT_W-1:0] amt);
		logic [IN_DATA_W-1:0] beat;
		beat = '0;
		beat[IN_POS_LO +: POS_W] = pos;
		beat[IN_SEL_LO +: BIN_W] = sel;
		beat[IN_AMT_LO +: AMT_W] = amt;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			if ($urandom_range(3, 0) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(8, 1)) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= beat;
		s_axis_tuser  <= m;
		do @(posedge clk); while (!s_axis_tready);
		pending_reports.push_back(bin_command(m, pos, sel, amt));
	endtask

	// stop sending and let every outstanding result come back
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_UPPER_EDGE:  upper_pos = data;
			CFG_BIN_WIDTH:   width_cfg = data[BW_W-1:0];
			CFG_BINS_IN_USE: bins_cfg  = data[BIU_W-1:0];
			default: ;
		endcase
	endtask

	task automatic random_beat();
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 55)
			send_beat(MODE_BIN, pos_near_bin(), BIN_W'($urandom), $urandom);
		else if (pick < 65)
			send_beat(MODE_BIN, $urandom, BIN_W'($urandom), $urandom);
		else if (pick < 77)
			send_beat(MODE_LOST, $urandom, BIN_W'($urandom),
				$urandom_range(1, 0) ? $urandom_range(8, 0) : $urandom);
		else if (pick < 87) begin
			case ($urandom_range(3, 0))
				0:       send_beat(MODE_SET, $urandom, BIN_W'($urandom), $urandom);
				1:       send_beat(MODE_SET, $urandom, BIN_W'($urandom),
						32'hFFFF_FFF0 + $urandom_range(15, 0));
				default: send_beat(MODE_SET, $urandom, BIN_W'($urandom),
						$urandom_range(100, 0));
			endcase
		end else
			send_beat(MODE_READ, $urandom, BIN_W'($urandom), $urandom);
	endtask

	task automatic test_reset_contents();
		send_beat(MODE_READ, '0, '0, '0);
		send_beat(MODE_READ, '1, 6'd63, '1);
		settle();
	endtask

	task automatic test_bin_edges();
		set_reg(CFG_UPPER_EDGE, '0);
		set_reg(CFG_BIN_WIDTH, 32'd1);
		set_reg(CFG_BINS_IN_USE, 32'd64);
		send_beat(MODE_BIN, 32'sd0, '0, '0);
		send_beat(MODE_BIN, 32'sd0, '0, '0);
		send_beat(MODE_BIN, -32'sd63, '0, '0);
		send_beat(MODE_BIN, 32'sd63, '0, '0);
		send_beat(MODE_BIN, 32'sd64, '0, '0);
		send_beat(MODE_BIN, POS_MIN, '0, '0);
		send_beat(MODE_BIN, POS_MAX, '0, '0);
		settle();
		// widest span: the 33-bit difference divided by the widest bin
		set_reg(CFG_UPPER_EDGE, POS_MAX);
		set_reg(CFG_BIN_WIDTH, 32'h7FFF_FFFF);
		set_reg(CFG_BINS_IN_USE, 32'd127);
		send_beat(MODE_BIN, POS_MIN, '0, '0);
		send_beat(MODE_BIN, POS_MAX, '0, '0);
		settle();
		set_reg(CFG_UPPER_EDGE, POS_MIN);
		send_beat(MODE_BIN, POS_MAX, '0, '0);
		send_beat(MODE_BIN, POS_MIN, '0, '0);
		settle();
	endtask

	task automatic test_degenerate_config();
		set_reg(CFG_BIN_WIDTH, 32'h8000_0000);
		send_beat(MODE_BIN, POS_MIN, '0, '0);
		settle();
		set_reg(CFG_BIN_WIDTH, 32'd1);
		set_reg(CFG_BINS_IN_USE, 32'd0);
		send_beat(MODE_BIN, POS_MIN, '0, '0);
		settle();
	endtask

	task automatic test_count_commands();
		send_beat(MODE_SET, '0, 6'd5, 32'd10);
		send_beat(MODE_LOST, '0, 6'd5, 32'd3);
		send_beat(MODE_LOST, '0, 6'd5, 32'd100);
		// bin at the emitted limit is left alone
		send_beat(MODE_LOST, '0, 6'd6, 32'd1);
		send_beat(MODE_READ, '0, 6'd6, '0);
		send_beat(MODE_SET, '0, 6'd63, 32'hFFFF_FFFF);
		send_beat(MODE_LOST, '0, 6'd62, 32'd1);
		settle();
	endtask

	task automatic test_saturation();
		set_reg(CFG_UPPER_EDGE, '0);
		set_reg(CFG_BINS_IN_USE, 32'd64);
		send_beat(MODE_BIN, -32'sd63, '0, '0);
		send_beat(MODE_READ, '0, 6'd63, '0);
		settle();
	endtask

	task automatic test_backpressure();
		hold_req = ~hold_req;
		burst_left = 60;
		repeat (60) random_beat();
		settle();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					set_reg(CFG_UPPER_EDGE, $urandom);
					set_reg(CFG_BIN_WIDTH, $urandom_range(16, 1));
					set_reg(CFG_BINS_IN_USE, 32'd64);
				end
				1: begin
					set_reg(CFG_UPPER_EDGE, $urandom);
					set_reg(CFG_BIN_WIDTH, $urandom);
					set_reg(CFG_BINS_IN_USE, $urandom_range(64, 1));
				end
				2: begin
					set_reg(CFG_UPPER_EDGE, POS_MIN);
					set_reg(CFG_BIN_WIDTH, 32'd1 << 26);
					set_reg(CFG_BINS_IN_USE, 32'd127);
				end
				3: begin
					set_reg(CFG_UPPER_EDGE, $urandom);
					set_reg(CFG_BIN_WIDTH, $urandom_range(1000, 1));
					set_reg(CFG_BINS_IN_USE, 32'd1);
				end
				4: begin
					set_reg(CFG_UPPER_EDGE, POS_MAX);
					set_reg(CFG_BIN_WIDTH, 32'd1);
					set_reg(CFG_BINS_IN_USE, $urandom_range(127, 65));
				end
				default: begin
					set_reg(CFG_UPPER_EDGE, $urandom);
					set_reg(CFG_BIN_WIDTH, $urandom_range(1 << 20, 1));
					set_reg(CFG_BINS_IN_USE, $urandom_range(63, 2));
				end
			endcase
			repeat (PHASE_BEATS) random_beat();
			settle();
			if (ph == 1)
				test_backpressure();
		end
	endtask

	// receiver: long hold-off on request, otherwise a stall pattern of its own
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				stall_style  = $urandom_range(3, 0);
				pattern_left = $urandom_range(200, 20);
			end
			pattern_left--;
			case (stall_style)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= $urandom_range(1, 0);
				2:       m_axis_tready <= ($urandom_range(3, 0) == 0);
				default: m_axis_tready <= (pattern_left % 5 != 0);
			endcase
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		bin_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result beat, expected none, actual tdata %h tuser %b",
					$time, m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_reports.pop_front();
				check_field("bin_index", 32'(want.idx),
					32'(m_axis_tdata[OUT_IDX_LO +: BIN_W]));
				check_field("out_of_range", 32'(want.oor), 32'(m_axis_tuser));
				check_field("bin_count", want.cnt, m_axis_tdata[OUT_CNT_LO +: OCNT_W]);
				check_field("bin_min", want.lo, m_axis_tdata[OUT_MIN_LO +: POS_W]);
				check_field("bin_max", want.hi, m_axis_tdata[OUT_MAX_LO +: POS_W]);
				check_field("bin_emitted", 32'(want.emit), 32'(m_axis_tdata[OUT_EMIT_LO]));
			end
		end
	end

	initial begin
		upper_pos  = UPPER_EDGE_RST;
		width_cfg  = BIN_WIDTH_RST;
		bins_cfg   = BINS_IN_USE_RST;
		emit_limit = 0;
		for (int i = 0; i < NUM_BINS_DEF; i++) begin
			hist_count[i]   = '0;
			hist_lo[i]      = POS_MAX;
			hist_hi[i]      = POS_MIN;
			hist_emitted[i] = 1'b0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_bin_edges();
		test_degenerate_config();
		test_count_commands();
		test_saturation();
		test_random_phases();

		if (fail_count == 0 && pending_reports.size() == 0)
			$display("position_histogram_with_extrema regression: pass");
		else
			$display("position_histogram_with_extrema regression: fail");
		$finish;
	end

endmodule

// ===== position_histogram_with_extrema.f =====
rtl/phe_pkg.sv
rtl/phe_divider.sv
rtl/position_histogram_with_extrema.sv
test/position_histogram_with_extrema_tb.sv
